/* rtl/stl_pkg.sv */
// Package with shared types, constants and helper functions of the script token lexer.
package stl_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned LINE_BITS_DEF     = 16;
  localparam int unsigned LENGTH_BITS_DEF   = 8;
  localparam int unsigned KW_DEPTH          = 6;
  localparam int unsigned MAX_TOKENS        = 3;

  // Scanner modes.
  typedef enum logic [13:0] {
    MD_IDLE     = 14'b00000000000001,
    MD_SLASH    = 14'b00000000000010,
    MD_COMMENT  = 14'b00000000000100,
    MD_IDENT    = 14'b00000000001000,
    MD_NUMBER   = 14'b00000000010000,
    MD_NUMDOT   = 14'b00000000100000,
    MD_FRACTION = 14'b00000001000000,
    MD_STRING   = 14'b00000010000000,
    MD_BANG     = 14'b00000100000000,
    MD_BANGEQ   = 14'b00001000000000,
    MD_EQ       = 14'b00010000000000,
    MD_EQEQ     = 14'b00100000000000,
    MD_LESS     = 14'b01000000000000,
    MD_GREATER  = 14'b10000000000000
  } mode_t;

  // Token kinds.
  localparam logic [5:0] K_LPAREN = 6'd0;
  localparam logic [5:0] K_RPAREN = 6'd1;
  localparam logic [5:0] K_LBRACE = 6'd2;
  localparam logic [5:0] K_RBRACE = 6'd3;
  localparam logic [5:0] K_COMMA  = 6'd4;
  localparam logic [5:0] K_DOT    = 6'd5;
  localparam logic [5:0] K_MINUS  = 6'd6;
  localparam logic [5:0] K_PLUS   = 6'd7;
  localparam logic [5:0] K_SEMI   = 6'd8;
  localparam logic [5:0] K_SLASH  = 6'd9;
  localparam logic [5:0] K_STAR   = 6'd10;
  localparam logic [5:0] K_BANG   = 6'd11;
  localparam logic [5:0] K_BANGEQ = 6'd12;
  localparam logic [5:0] K_BANGEQEQ = 6'd13;
  localparam logic [5:0] K_EQ     = 6'd14;
  localparam logic [5:0] K_EQEQ   = 6'd15;
  localparam logic [5:0] K_EQEQEQ = 6'd16;
  localparam logic [5:0] K_GT     = 6'd17;
  localparam logic [5:0] K_GE     = 6'd18;
  localparam logic [5:0] K_LT     = 6'd19;
  localparam logic [5:0] K_LE     = 6'd20;
  localparam logic [5:0] K_IDENT  = 6'd21;
  localparam logic [5:0] K_STRING = 6'd22;
  localparam logic [5:0] K_NUMBER = 6'd23;
  localparam logic [5:0] K_KW0    = 6'd24;
  localparam logic [5:0] K_ERROR  = 6'd40;
  localparam logic [5:0] K_EOF    = 6'd41;

  // Error reasons.
  localparam logic [1:0] ER_NONE     = 2'd0;
  localparam logic [1:0] ER_UNTERM   = 2'd1;
  localparam logic [1:0] ER_UNEXPECT = 2'd2;

  typedef logic [KW_DEPTH-1:0][7:0] kwbuf_t;

  // Keyword table: text padded with zero bytes, index 15 listed first.
  localparam logic [15:0][47:0] KW_TEXT = {
    48'h00_65_6c_69_68_77, // while
    48'h00_00_00_72_61_76, // var
    48'h00_00_65_75_72_74, // true
    48'h00_00_73_69_68_74, // this
    48'h00_72_65_70_75_73, // super
    48'h6e_72_75_74_65_72, // return
    48'h00_74_6e_69_72_70, // print
    48'h00_00_00_00_72_6f, // or
    48'h00_00_00_6c_69_6e, // nil
    48'h00_00_00_00_66_69, // if
    48'h00_00_63_6e_75_66, // func
    48'h00_00_00_72_6f_66, // for
    48'h00_65_73_6c_61_66, // false
    48'h00_00_65_73_6c_65, // else
    48'h00_73_73_61_6c_63, // class
    48'h00_00_00_64_6e_61  // and
  };
  localparam logic [15:0][2:0] KW_LEN = {
    3'd5, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6, 3'd5, 3'd2,
    3'd3, 3'd2, 3'd4, 3'd3, 3'd5, 3'd4, 3'd5, 3'd3
  };

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

/* rtl/stl_if.sv */
// Valid/ready stream interfaces for the input and result channels.
interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       source_end;
  modport source (output valid, output char_byte, output source_end, input ready);
  modport sink (input valid, input char_byte, input source_end, output ready);
endinterface

interface stl_out_if #(
  parameter int unsigned POSITION_BITS = stl_pkg::POSITION_BITS_DEF,
  parameter int unsigned LINE_BITS     = stl_pkg::LINE_BITS_DEF,
  parameter int unsigned LENGTH_BITS   = stl_pkg::LENGTH_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [5:0]               token_kind;
  logic [POSITION_BITS-1:0] token_start;
  logic [LENGTH_BITS-1:0]   token_length;
  logic [LINE_BITS-1:0]     token_line;
  logic [1:0]               error_reason;
  logic                     last_of_run;
  modport source (output valid, output token_kind, output token_start, output token_length,
                  output token_line, output error_reason, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start, input token_length,
                input token_line, input error_reason, input last_of_run, output ready);
endinterface

/* rtl/script_token_lexer_unit.sv */
// Top level of the script token lexer: scanner state, token formation and result queue.
//
//   channel | dir | beat contents
//   in_     | in  | char_byte, source_end
//   out_    | out | token kind, start, length, line, error reason, last of run
//
// One source byte is taken every cycle while the queue has room; its zero to three
// tokens are written into an eight-entry result queue in the same edge and leave one
// per cycle while the sink is ready. Input is held off only while the queue lacks
// room for three more tokens.
// Reset (synchronous, active low) clears the scanner and empties the queue.
module script_token_lexer_unit #(
  parameter int unsigned POSITION_BITS = stl_pkg::POSITION_BITS_DEF,
  parameter int unsigned LINE_BITS     = stl_pkg::LINE_BITS_DEF,
  parameter int unsigned LENGTH_BITS   = stl_pkg::LENGTH_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  stl_in_if.sink     in,
  stl_out_if.source  out
);
  localparam int unsigned TW = 6 + POSITION_BITS + LENGTH_BITS + LINE_BITS + 3;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

  stl_pkg::mode_t           mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, begin_r, begin_nxt;
  logic [LENGTH_BITS-1:0]   cnt_r, cnt_nxt;
  logic [LINE_BITS-1:0]     line_r, line_nxt;
  stl_pkg::kwbuf_t          kw_r, kw_nxt;
  logic [5:0]               id_kind;
  logic                     accept, space_ok;
  logic [1:0]               n;
  logic [stl_pkg::MAX_TOKENS-1:0][TW-1:0] toks;

  assign in.ready = space_ok;
  assign accept   = in.valid && in.ready;

  stl_kw_match #(.LENGTH_BITS(LENGTH_BITS)) u_kw (
    .kw_buf(kw_r), .count(cnt_r), .kind(id_kind));

  function automatic logic [LENGTH_BITS-1:0] sat_add(input logic [LENGTH_BITS-1:0] a,
                                                      input logic [1:0] b);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, a} + (LENGTH_BITS+1)'(b);
    return s[LENGTH_BITS] ? LEN_MAX : s[LENGTH_BITS-1:0];
  endfunction

  // Scanner: one byte, zero to three tokens.
  always_comb begin
    logic [7:0] c;
    logic       redo, stop, disp;
    logic [LINE_BITS-1:0] ln;
    c = in.char_byte;
    mode_nxt = mode_r; begin_nxt = begin_r; cnt_nxt = cnt_r; kw_nxt = kw_r;
    ln = line_r; n = 2'd0; toks = '0;
    redo = 1'b0; disp = 1'b0;
    stop = in.source_end || c == 8'h00;
    pos_nxt = pos_r + POSITION_BITS'(1);

    // Pending token, emitted on flush or on a byte that ends it.
    begin : fin_blk
      logic do_fin;
      do_fin = 1'b0;
      if (!stop) begin
        unique case (mode_r)
          stl_pkg::MD_IDLE: disp = 1'b1;
          stl_pkg::MD_SLASH:
            if (c == 8'h2f) mode_nxt = stl_pkg::MD_COMMENT; else redo = 1'b1;
          stl_pkg::MD_COMMENT:
            if (c == 8'h0a) begin mode_nxt = stl_pkg::MD_IDLE; disp = 1'b1; end
          stl_pkg::MD_IDENT:
            if (stl_pkg::is_letter(c) || stl_pkg::is_digit(c)) begin
              for (int i = 1; i < int'(stl_pkg::KW_DEPTH); i++)
                if (cnt_r == LENGTH_BITS'(i)) kw_nxt[i] = c;
              cnt_nxt = sat_add(cnt_r, 2'd1);
            end else redo = 1'b1;
          stl_pkg::MD_NUMBER:
            if (stl_pkg::is_digit(c)) cnt_nxt = sat_add(cnt_r, 2'd1);
            else if (c == 8'h2e) mode_nxt = stl_pkg::MD_NUMDOT;
            else redo = 1'b1;
          stl_pkg::MD_NUMDOT:
            if (stl_pkg::is_digit(c)) begin
              cnt_nxt = sat_add(cnt_r, 2'd2); mode_nxt = stl_pkg::MD_FRACTION;
            end else redo = 1'b1;
          stl_pkg::MD_FRACTION:
            if (stl_pkg::is_digit(c)) cnt_nxt = sat_add(cnt_r, 2'd1); else redo = 1'b1;
          stl_pkg::MD_STRING: begin
            cnt_nxt = sat_add(cnt_r, 2'd1);
            if (c == 8'h22) begin
              toks[0] = {stl_pkg::K_STRING, begin_r, cnt_nxt, ln, stl_pkg::ER_NONE, 1'b0};
              n = 2'd1; mode_nxt = stl_pkg::MD_IDLE;
            end else if (c == 8'h0a && ln != LINE_MAX) ln = ln + LINE_BITS'(1);
          end
          stl_pkg::MD_BANG, stl_pkg::MD_EQ:
            if (c == 8'h3d) begin
              cnt_nxt = LENGTH_BITS'(2);
              mode_nxt = (mode_r == stl_pkg::MD_BANG) ? stl_pkg::MD_BANGEQ : stl_pkg::MD_EQEQ;
            end else redo = 1'b1;
          stl_pkg::MD_BANGEQ, stl_pkg::MD_EQEQ:
            if (c == 8'h3d) begin
              toks[0] = {(mode_r == stl_pkg::MD_BANGEQ) ? stl_pkg::K_BANGEQEQ
                         : stl_pkg::K_EQEQEQ, begin_r, LENGTH_BITS'(3), ln,
                         stl_pkg::ER_NONE, 1'b0};
              n = 2'd1; mode_nxt = stl_pkg::MD_IDLE;
            end else redo = 1'b1;
          stl_pkg::MD_LESS, stl_pkg::MD_GREATER:
            if (c == 8'h3d) begin
              toks[0] = {(mode_r == stl_pkg::MD_LESS) ? stl_pkg::K_LE : stl_pkg::K_GE,
                         begin_r, LENGTH_BITS'(2), ln, stl_pkg::ER_NONE, 1'b0};
              n = 2'd1; mode_nxt = stl_pkg::MD_IDLE;
            end else redo = 1'b1;
          default: disp = 1'b1;
        endcase
      end
      do_fin = stop || redo;
      if (do_fin) begin
        mode_nxt = stl_pkg::MD_IDLE;
        unique case (mode_r)
          stl_pkg::MD_SLASH: begin
            toks[0] = {stl_pkg::K_SLASH, begin_r, LENGTH_BITS'(1), ln, stl_pkg::ER_NONE, 1'b0};
            n = 2'd1;
          end
          stl_pkg::MD_IDENT: begin
            toks[0] = {(cnt_r > LENGTH_BITS'(stl_pkg::KW_DEPTH)) ? stl_pkg::K_IDENT : id_kind,
                       begin_r, cnt_r, ln, stl_pkg::ER_NONE, 1'b0};
            n = 2'd1;
          end
          stl_pkg::MD_NUMBER, stl_pkg::MD_FRACTION: begin
            toks[0] = {stl_pkg::K_NUMBER, begin_r, cnt_r, ln, stl_pkg::ER_NONE, 1'b0};
            n = 2'd1;
          end
          stl_pkg::MD_NUMDOT: begin
            toks[0] = {stl_pkg::K_NUMBER, begin_r, cnt_r, ln, stl_pkg::ER_NONE, 1'b0};
            toks[1] = {stl_pkg::K_DOT, pos_r - POSITION_BITS'(1), LENGTH_BITS'(1), ln,
                       stl_pkg::ER_NONE, 1'b0};
            n = 2'd2;
          end
          stl_pkg::MD_STRING: begin
            toks[0] = {stl_pkg::K_ERROR, begin_r, cnt_r, ln, stl_pkg::ER_UNTERM, 1'b0};
            n = 2'd1;
          end
          stl_pkg::MD_BANG: begin
            toks[0] = {stl_pkg::K_BANG, begin_r, LENGTH_BITS'(1), ln, stl_pkg::ER_NONE, 1'b0};
            n = 2'd1;
          end
          stl_pkg::MD_BANGEQ: begin
            toks[0] = {stl_pkg::K_BANGEQ, begin_r, LENGTH_BITS'(2), ln, stl_pkg::ER_NONE, 1'b0};
            n = 2'd1;
          end
          stl_pkg::MD_EQ: begin
            toks[0] = {stl_pkg::K_EQ, begin_r, LENGTH_BITS'(1), ln, stl_pkg::ER_NONE, 1'b0};
            n = 2'd1;
          end
          stl_pkg::MD_EQEQ: begin
            toks[0] = {stl_pkg::K_EQEQ, begin_r, LENGTH_BITS'(2), ln, stl_pkg::ER_NONE, 1'b0};
            n = 2'd1;
          end
          stl_pkg::MD_LESS: begin
            toks[0] = {stl_pkg::K_LT, begin_r, LENGTH_BITS'(1), ln, stl_pkg::ER_NONE, 1'b0};
            n = 2'd1;
          end
          stl_pkg::MD_GREATER: begin
            toks[0] = {stl_pkg::K_GT, begin_r, LENGTH_BITS'(1), ln, stl_pkg::ER_NONE, 1'b0};
            n = 2'd1;
          end
          default: ;
        endcase
        if (redo) disp = 1'b1;
      end
    end

    // Dispatch of a byte from the idle mode.
    if (disp) begin
      logic [5:0] kd;
      logic       single;
      logic [1:0] rs;
      kd = stl_pkg::K_ERROR; single = 1'b1; rs = stl_pkg::ER_NONE;
      if (stl_pkg::is_letter(c)) begin
        mode_nxt = stl_pkg::MD_IDENT; begin_nxt = pos_r; cnt_nxt = LENGTH_BITS'(1);
        kw_nxt[0] = c; single = 1'b0;
      end else if (stl_pkg::is_digit(c)) begin
        mode_nxt = stl_pkg::MD_NUMBER; begin_nxt = pos_r; cnt_nxt = LENGTH_BITS'(1);
        single = 1'b0;
      end else begin
        case (c)
          8'h20, 8'h0d, 8'h09: single = 1'b0;
          8'h0a: begin
            single = 1'b0;
            if (ln != LINE_MAX) ln = ln + LINE_BITS'(1);
          end
          8'h22, 8'h2f, 8'h21, 8'h3d, 8'h3c, 8'h3e: begin
            single = 1'b0; begin_nxt = pos_r; cnt_nxt = LENGTH_BITS'(1);
            case (c)
              8'h22:   mode_nxt = stl_pkg::MD_STRING;
              8'h2f:   mode_nxt = stl_pkg::MD_SLASH;
              8'h21:   mode_nxt = stl_pkg::MD_BANG;
              8'h3d:   mode_nxt = stl_pkg::MD_EQ;
              8'h3c:   mode_nxt = stl_pkg::MD_LESS;
              default: mode_nxt = stl_pkg::MD_GREATER;
            endcase
          end
          8'h28: kd = stl_pkg::K_LPAREN;
          8'h29: kd = stl_pkg::K_RPAREN;
          8'h7b: kd = stl_pkg::K_LBRACE;
          8'h7d: kd = stl_pkg::K_RBRACE;
          8'h2c: kd = stl_pkg::K_COMMA;
          8'h2e: kd = stl_pkg::K_DOT;
          8'h2d: kd = stl_pkg::K_MINUS;
          8'h2b: kd = stl_pkg::K_PLUS;
          8'h3b: kd = stl_pkg::K_SEMI;
          8'h2a: kd = stl_pkg::K_STAR;
          default: rs = stl_pkg::ER_UNEXPECT;
        endcase
      end
      if (single) begin
        toks[n] = {kd, pos_r, LENGTH_BITS'(1), ln, rs, 1'b0};
        n = n + 2'd1;
      end
    end

    // End of source: EOF token and return to the reset state.
    if (stop) begin
      toks[n] = {stl_pkg::K_EOF, pos_r, LENGTH_BITS'(0), ln, stl_pkg::ER_NONE, 1'b0};
      n = n + 2'd1;
      pos_nxt = '0; begin_nxt = '0; cnt_nxt = '0; ln = LINE_BITS'(1);
      mode_nxt = stl_pkg::MD_IDLE;
    end
    line_nxt = ln;
    if (n != 2'd0) toks[n - 2'd1][0] = 1'b1;
  end

  // Scanner state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stl_pkg::MD_IDLE; pos_r <= '0; begin_r <= '0; cnt_r <= '0;
      line_r <= LINE_BITS'(1);
    end else if (accept) begin
      mode_r <= mode_nxt; pos_r <= pos_nxt; begin_r <= begin_nxt; cnt_r <= cnt_nxt;
      line_r <= line_nxt;
    end
  end

  // Identifier byte buffer, no reset.
  always_ff @(posedge clk) begin
    if (accept) kw_r <= kw_nxt;
  end

  stl_out_queue #(.POSITION_BITS(POSITION_BITS), .LINE_BITS(LINE_BITS),
                  .LENGTH_BITS(LENGTH_BITS)) u_q (
    .clk(clk), .rst_n(rst_n), .push_n(accept ? n : 2'd0), .push_tok(toks),
    .space_ok(space_ok), .out(out));

  // Every accepted end beat produces at least the EOF token.
  a_eof_push: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in.source_end |-> n != 2'd0) else $error("end beat without tokens");
  // An end beat returns the scanner to its start state.
  a_eof_reset: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in.source_end |=> pos_r == '0 && mode_r == stl_pkg::MD_IDLE)
    else $error("scanner not restarted after end");
  // Line number never drops to zero.
  a_line_nz: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0) else $error("line number zero");
endmodule

/* rtl/stl_kw_match.sv */
// Keyword matcher: maps a buffered identifier to its token kind.
module stl_kw_match #(
  parameter int unsigned LENGTH_BITS = stl_pkg::LENGTH_BITS_DEF
) (
  input  stl_pkg::kwbuf_t        kw_buf,
  input  logic [LENGTH_BITS-1:0] count,
  output logic [5:0]             kind
);
  // Compare every keyword in parallel; only written bytes take part.
  always_comb begin
    logic hit;
    kind = stl_pkg::K_IDENT;
    for (int k = 0; k < 16; k++) begin
      hit = (count == LENGTH_BITS'(stl_pkg::KW_LEN[k]));
      for (int b = 0; b < int'(stl_pkg::KW_DEPTH); b++) begin
        if (b < int'(stl_pkg::KW_LEN[k]) && kw_buf[b] != stl_pkg::KW_TEXT[k][b*8 +: 8])
          hit = 1'b0;
      end
      if (hit) kind = stl_pkg::K_KW0 + 6'(k);
    end
  end
endmodule

/* rtl/stl_out_queue.sv */
// Result queue: holds up to eight tokens and signals room while three more fit for the next byte.
module stl_out_queue #(
  parameter int unsigned POSITION_BITS = stl_pkg::POSITION_BITS_DEF,
  parameter int unsigned LINE_BITS     = stl_pkg::LINE_BITS_DEF,
  parameter int unsigned LENGTH_BITS   = stl_pkg::LENGTH_BITS_DEF,
  localparam int unsigned TW = 6 + POSITION_BITS + LENGTH_BITS + LINE_BITS + 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [1:0]                          push_n,
  input  logic [stl_pkg::MAX_TOKENS-1:0][TW-1:0] push_tok,
  output logic                                space_ok,
  stl_out_if.source                           out
);
  localparam int unsigned DEPTH = 8;
  logic [TW-1:0] mem_r [DEPTH];
  logic [2:0]    wp_r, rp_r;
  logic [3:0]    cnt_r, cnt_nxt;
  logic          pop;

  assign pop      = out.valid && out.ready;
  assign out.valid = cnt_r != 4'd0;
  assign space_ok = cnt_r <= 4'(DEPTH - stl_pkg::MAX_TOKENS);
  assign {out.token_kind, out.token_start, out.token_length, out.token_line,
          out.error_reason, out.last_of_run} = mem_r[rp_r];
  assign cnt_nxt = cnt_r + 4'(push_n) - 4'(pop);

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + 3'(push_n);
      rp_r  <= rp_r + 3'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  // Token storage.
  always_ff @(posedge clk) begin
    for (int i = 0; i < int'(stl_pkg::MAX_TOKENS); i++) begin
      if (i < int'(push_n)) mem_r[wp_r + 3'(i)] <= push_tok[i];
    end
  end
endmodule
